@@ hw/rtl/gn3_pkg.sv @@
// ----------------------------------------------------------------------------
// gn3_pkg
// Shared types and constants for the 3D gradient noise unit.
// ----------------------------------------------------------------------------
package gn3_pkg;

	localparam int TABLE_SIZE    = 256;
	localparam int IDX_W         = $clog2(TABLE_SIZE);
	localparam int BYTE_W        = 8;
	localparam int COORD_W       = 24;
	localparam int OUT_W         = 18;
	localparam int OUT_FRAC      = 16;
	localparam int FRAC_BITS_DEF = 16;

	// request opcode
	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_EVAL = 1'b1
	} cmd_t;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [COORD_W-1:0] coord_t;
	typedef logic signed [OUT_W-1:0] noise_t;

endpackage

@@ hw/rtl/gn3_in_if.sv @@
// ----------------------------------------------------------------------------
// gn3_in_if
// Request channel: table load or noise evaluation at one point.
// ----------------------------------------------------------------------------
interface gn3_in_if;
	logic             valid;
	logic             ready;
	gn3_pkg::cmd_t    command;
	gn3_pkg::idx_t    table_index;
	gn3_pkg::byte_t   table_value;
	gn3_pkg::coord_t  coord_x;
	gn3_pkg::coord_t  coord_y;
	gn3_pkg::coord_t  coord_z;

	modport source (output valid, command, table_index, table_value,
		coord_x, coord_y, coord_z, input ready);
	modport sink (input valid, command, table_index, table_value,
		coord_x, coord_y, coord_z, output ready);
endinterface

@@ hw/rtl/gn3_out_if.sv @@
// ----------------------------------------------------------------------------
// gn3_out_if
// Result channel: one saturated Q1.16 noise sample.
// ----------------------------------------------------------------------------
interface gn3_out_if;
	logic            valid;
	logic            ready;
	gn3_pkg::noise_t noise_value;

	modport source (output valid, noise_value, input ready);
	modport sink (input valid, noise_value, output ready);
endinterface

@@ hw/rtl/gn3_perm_mem.sv @@
// ----------------------------------------------------------------------------
// gn3_perm_mem
// One copy of the permutation table: one write port, two registered reads.
// ----------------------------------------------------------------------------
module gn3_perm_mem (
	input  logic           clk,
	input  logic           en,
	input  logic           we,
	input  gn3_pkg::idx_t  waddr,
	input  gn3_pkg::byte_t wdata,
	input  gn3_pkg::idx_t  raddr0,
	input  gn3_pkg::idx_t  raddr1,
	output gn3_pkg::byte_t rdata0,
	output gn3_pkg::byte_t rdata1
);
	import gn3_pkg::*;

	byte_t mem [TABLE_SIZE];

	// write and registered reads; reads hold during a stall
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (en) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end
endmodule

@@ hw/rtl/gn3_fade.sv @@
// ----------------------------------------------------------------------------
// gn3_fade
// Quintic fade 6t^5-15t^4+10t^3, three register stages, one multiply each.
// ----------------------------------------------------------------------------
module gn3_fade #(
	parameter int FRAC_BITS = gn3_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [FRAC_BITS-1:0] t,
	output logic [FRAC_BITS:0]   fade
);
	import gn3_pkg::*;

	localparam int F  = FRAC_BITS;
	localparam int QW = F + 4;

	logic [F-1:0]    t_s2, t2_s2, t3_s3;
	logic [QW-1:0]   q_s3;
	logic [2*F-1:0]  sq, cube;
	logic [F+QW-1:0] prod;
	logic [QW:0]     q_full;

	assign sq   = (2*F)'(t) * (2*F)'(t);
	assign cube = (2*F)'(t2_s2) * (2*F)'(t_s2);

	// q = 6*t2 + 10*one - 15*t
	assign q_full = ((QW+1)'(t2_s2) << 2) + ((QW+1)'(t2_s2) << 1)
		+ ((QW+1)'(10) << F) - ((QW+1)'(t_s2) << 4) + (QW+1)'(t_s2);

	assign prod = (F+QW)'(t3_s3) * (F+QW)'(q_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			t_s2  <= t;
			t2_s2 <= sq[2*F-1:F];
			t3_s3 <= cube[2*F-1:F];
			q_s3  <= q_full[QW-1:0];
			fade  <= prod[F +: F+1];
		end
	end
endmodule

@@ hw/rtl/gradient_noise_3d_unit.sv @@
// ----------------------------------------------------------------------------
// gradient_noise_3d_unit
// Improved 3D gradient noise, one point per cycle unless stalled, 7 stages.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  in_ch   | in  | command, table_index, table_value, coord_x/y/z
//  out_ch  | out | noise_value (signed Q1.16, saturated)
//
// Requests pass through stages s1 to s7; one request per cycle unless stalled.
// The table is held in seven copies (1 + 2 + 4), each written as a load
// passes its stage, so lookups of all eight corners fit in three stages.
// Reset clears only the valid bits; the table is undefined until loaded.
// A stall at the output freezes every stage; loads give no result.
module gradient_noise_3d_unit #(
	parameter int FRAC_BITS = gn3_pkg::FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	gn3_in_if.sink    in_ch,
	gn3_out_if.source out_ch
);
	import gn3_pkg::*;

	localparam int F  = FRAC_BITS;
	localparam int PW = F + 2;
	localparam int GW = F + 3;
	localparam int CW = GW + OUT_FRAC + 2;
	localparam logic signed [PW-1:0] ONE_P = PW'(1) << F;
	localparam logic signed [CW-1:0] SAT_MAX = CW'((1 << (OUT_W-1)) - 1);
	localparam logic signed [CW-1:0] SAT_MIN = -CW'(1 << (OUT_W-1));

	typedef logic signed [GW-1:0] gv_t;

	function automatic gv_t grad_f(input logic [3:0] h, input logic signed [PW-1:0] x,
		input logic signed [PW-1:0] y, input logic signed [PW-1:0] z);
		gv_t u, v;
		u = (h < 4'd8) ? GW'(x) : GW'(y);
		if (h < 4'd4) begin
			v = GW'(y);
		end else if (h == 4'd12 || h == 4'd14) begin
			v = GW'(x);
		end else begin
			v = GW'(z);
		end
		return (h[0] ? -u : u) + (h[1] ? -v : v);
	endfunction

	// a + floor(s * (b - a) / 2^F)
	function automatic gv_t lerp_f(input gv_t a, input gv_t b, input logic [F:0] s);
		logic signed [GW:0]       diff;
		logic signed [GW+F+2:0]   prod;
		logic signed [GW+F+2:0]   shr;
		diff = (GW+1)'(b) - (GW+1)'(a);
		prod = (GW+F+3)'($signed({1'b0, s})) * (GW+F+3)'(diff);
		shr  = prod >>> F;
		return a + shr[GW-1:0];
	endfunction

	function automatic idx_t int_part(input coord_t c);
		logic [COORD_W+IDX_W-1:0] ext;
		ext = (COORD_W+IDX_W)'(c) >> F;
		return ext[IDX_W-1:0];
	endfunction

	logic en;
	assign en           = !out_ch.valid || out_ch.ready;
	assign in_ch.ready  = en;

	// stage control
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	cmd_t cmd_s1, cmd_s2, cmd_s3, cmd_s4, cmd_s5, cmd_s6, cmd_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0; vld_s2 <= 1'b0; vld_s3 <= 1'b0; vld_s4 <= 1'b0;
			vld_s5 <= 1'b0; vld_s6 <= 1'b0; vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_ch.valid;
			vld_s2 <= vld_s1; vld_s3 <= vld_s2; vld_s4 <= vld_s3;
			vld_s5 <= vld_s4; vld_s6 <= vld_s5; vld_s7 <= vld_s6;
		end
	end

	// stage payloads
	idx_t          idx_s1, idx_s2, yi_s1, zi_s1, zi_s2;
	byte_t         val_s1, val_s2;
	logic [F-1:0]  xf_s1, yf_s1, zf_s1, xf_s2, yf_s2, zf_s2, xf_s3, yf_s3, zf_s3;
	gv_t           g_s4 [8];
	gv_t           x_s5 [4];
	gv_t           y1_s6, y2_s6;
	logic [F:0]    u_s4, v_s4, w_s4, v_s5, w_s5, w_s6;
	noise_t        noise_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= in_ch.command;
			idx_s1 <= in_ch.table_index;
			val_s1 <= in_ch.table_value;
			yi_s1  <= int_part(in_ch.coord_y);
			zi_s1  <= int_part(in_ch.coord_z);
			xf_s1  <= in_ch.coord_x[F-1:0];
			yf_s1  <= in_ch.coord_y[F-1:0];
			zf_s1  <= in_ch.coord_z[F-1:0];
			cmd_s2 <= cmd_s1; idx_s2 <= idx_s1; val_s2 <= val_s1; zi_s2 <= zi_s1;
			xf_s2  <= xf_s1; yf_s2 <= yf_s1; zf_s2 <= zf_s1;
			cmd_s3 <= cmd_s2; xf_s3 <= xf_s2; yf_s3 <= yf_s2; zf_s3 <= zf_s2;
			cmd_s4 <= cmd_s3; cmd_s5 <= cmd_s4; cmd_s6 <= cmd_s5; cmd_s7 <= cmd_s6;
		end
	end

	// first lookup: P[xi], P[xi+1]
	logic we_a, we_b, we_c;
	idx_t xi_in;
	byte_t pa_s1, pb_s1;
	assign xi_in = int_part(in_ch.coord_x);
	assign we_a  = en && in_ch.valid && (in_ch.command == CMD_LOAD);
	assign we_b  = en && vld_s1 && (cmd_s1 == CMD_LOAD);
	assign we_c  = en && vld_s2 && (cmd_s2 == CMD_LOAD);

	gn3_perm_mem u_mem_a (
		.clk(clk), .en(en), .we(we_a), .waddr(in_ch.table_index),
		.wdata(in_ch.table_value), .raddr0(xi_in), .raddr1(xi_in + idx_t'(1)),
		.rdata0(pa_s1), .rdata1(pb_s1)
	);

	// second lookup: P[a], P[a+1], P[b], P[b+1]
	idx_t a_s1, b_s1;
	byte_t pa0_s2, pa1_s2, pb0_s2, pb1_s2;
	assign a_s1 = pa_s1 + yi_s1;
	assign b_s1 = pb_s1 + yi_s1;

	gn3_perm_mem u_mem_b0 (
		.clk(clk), .en(en), .we(we_b), .waddr(idx_s1), .wdata(val_s1),
		.raddr0(a_s1), .raddr1(a_s1 + idx_t'(1)), .rdata0(pa0_s2), .rdata1(pa1_s2)
	);
	gn3_perm_mem u_mem_b1 (
		.clk(clk), .en(en), .we(we_b), .waddr(idx_s1), .wdata(val_s1),
		.raddr0(b_s1), .raddr1(b_s1 + idx_t'(1)), .rdata0(pb0_s2), .rdata1(pb1_s2)
	);

	// third lookup: corner hashes
	idx_t aa_s2, ab_s2, ba_s2, bb_s2;
	byte_t h_aa0, h_aa1, h_ab0, h_ab1, h_ba0, h_ba1, h_bb0, h_bb1;
	assign aa_s2 = pa0_s2 + zi_s2;
	assign ab_s2 = pa1_s2 + zi_s2;
	assign ba_s2 = pb0_s2 + zi_s2;
	assign bb_s2 = pb1_s2 + zi_s2;

	gn3_perm_mem u_mem_c0 (
		.clk(clk), .en(en), .we(we_c), .waddr(idx_s2), .wdata(val_s2),
		.raddr0(aa_s2), .raddr1(aa_s2 + idx_t'(1)), .rdata0(h_aa0), .rdata1(h_aa1)
	);
	gn3_perm_mem u_mem_c1 (
		.clk(clk), .en(en), .we(we_c), .waddr(idx_s2), .wdata(val_s2),
		.raddr0(ab_s2), .raddr1(ab_s2 + idx_t'(1)), .rdata0(h_ab0), .rdata1(h_ab1)
	);
	gn3_perm_mem u_mem_c2 (
		.clk(clk), .en(en), .we(we_c), .waddr(idx_s2), .wdata(val_s2),
		.raddr0(ba_s2), .raddr1(ba_s2 + idx_t'(1)), .rdata0(h_ba0), .rdata1(h_ba1)
	);
	gn3_perm_mem u_mem_c3 (
		.clk(clk), .en(en), .we(we_c), .waddr(idx_s2), .wdata(val_s2),
		.raddr0(bb_s2), .raddr1(bb_s2 + idx_t'(1)), .rdata0(h_bb0), .rdata1(h_bb1)
	);

	// fade curves, ready at stage 4
	gn3_fade #(.FRAC_BITS(F)) u_fade_x (.clk(clk), .en(en), .t(xf_s1), .fade(u_s4));
	gn3_fade #(.FRAC_BITS(F)) u_fade_y (.clk(clk), .en(en), .t(yf_s1), .fade(v_s4));
	gn3_fade #(.FRAC_BITS(F)) u_fade_z (.clk(clk), .en(en), .t(zf_s1), .fade(w_s4));

	// corner offsets
	logic signed [PW-1:0] xp, yp, zp, xm, ym, zm;
	assign xp = $signed(PW'(xf_s3));
	assign yp = $signed(PW'(yf_s3));
	assign zp = $signed(PW'(zf_s3));
	assign xm = xp - ONE_P;
	assign ym = yp - ONE_P;
	assign zm = zp - ONE_P;

	// gradients, then the x, y and z blends
	logic signed [CW-1:0] r_ext, r_conv;
	gv_t r_s6;
	assign r_s6  = lerp_f(y1_s6, y2_s6, w_s6);
	assign r_ext = CW'(r_s6);

	generate
		if (F >= OUT_FRAC) begin : g_down
			assign r_conv = r_ext >>> (F - OUT_FRAC);
		end else begin : g_up
			assign r_conv = r_ext <<< (OUT_FRAC - F);
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			g_s4[0] <= grad_f(h_aa0[3:0], xp, yp, zp);
			g_s4[1] <= grad_f(h_ba0[3:0], xm, yp, zp);
			g_s4[2] <= grad_f(h_ab0[3:0], xp, ym, zp);
			g_s4[3] <= grad_f(h_bb0[3:0], xm, ym, zp);
			g_s4[4] <= grad_f(h_aa1[3:0], xp, yp, zm);
			g_s4[5] <= grad_f(h_ba1[3:0], xm, yp, zm);
			g_s4[6] <= grad_f(h_ab1[3:0], xp, ym, zm);
			g_s4[7] <= grad_f(h_bb1[3:0], xm, ym, zm);
			x_s5[0] <= lerp_f(g_s4[0], g_s4[1], u_s4);
			x_s5[1] <= lerp_f(g_s4[2], g_s4[3], u_s4);
			x_s5[2] <= lerp_f(g_s4[4], g_s4[5], u_s4);
			x_s5[3] <= lerp_f(g_s4[6], g_s4[7], u_s4);
			v_s5    <= v_s4;
			w_s5    <= w_s4;
			y1_s6   <= lerp_f(x_s5[0], x_s5[1], v_s5);
			y2_s6   <= lerp_f(x_s5[2], x_s5[3], v_s5);
			w_s6    <= w_s5;
			if (r_conv > SAT_MAX) begin
				noise_s7 <= SAT_MAX[OUT_W-1:0];
			end else if (r_conv < SAT_MIN) begin
				noise_s7 <= SAT_MIN[OUT_W-1:0];
			end else begin
				noise_s7 <= r_conv[OUT_W-1:0];
			end
		end
	end

	assign out_ch.valid       = vld_s7 && (cmd_s7 == CMD_EVAL);
	assign out_ch.noise_value = noise_s7;

	// checks
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.noise_value))
		else $error("result changed while stalled");
	a_ready_only_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> out_ch.valid && !out_ch.ready)
		else $error("input held off without output stall");
	a_stage1_held: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !en |=> vld_s1 && $stable(xf_s1) && $stable(cmd_s1))
		else $error("stage 1 lost during stall");
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s7 && (cmd_s7 == CMD_LOAD) |-> !out_ch.valid)
		else $error("load produced a result");
endmodule
